[hw/rtl/gbr90_pkg.sv]
// Shared types, constants and geometry helpers for the glyph rotate block.
// No dependencies; gbr90_scatter, gbr90_dest and the top level import this package.
package gbr90_pkg;

  localparam int MaxWidth  = 32;
  localparam int MaxHeight = 32;
  localparam int RowW      = MaxWidth;
  localparam int RowIdxW   = $clog2(MaxHeight);
  localparam int SizeW     = 6;
  localparam int CfgAddrW  = 3;
  localparam int CfgDataW  = 32;

  // Register indexes of the configuration port.
  typedef enum logic [CfgAddrW-1:0] {
    CFG_CELL_WIDTH  = 3'd0,
    CFG_CELL_HEIGHT = 3'd1,
    CFG_INK_WIDTH   = 3'd2,
    CFG_INK_HEIGHT  = 3'd3,
    CFG_CLOCKWISE   = 3'd4
  } cfg_idx_e;

  localparam logic [SizeW-1:0] CellWidthRst  = 6'd8;
  localparam logic [SizeW-1:0] CellHeightRst = 6'd16;
  localparam logic [SizeW-1:0] InkWidthRst   = 6'd8;
  localparam logic [SizeW-1:0] InkHeightRst  = 6'd16;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_EMIT
  } state_e;

  // Cell geometry, latched when the last row of a cell arrives.
  typedef struct packed {
    logic signed [6:0] shift;     // row alignment of a source word
    logic signed [6:0] col_base;  // destination column of source row 0
    logic [SizeW-1:0]  cw;
    logic [SizeW-1:0]  ch;
    logic [SizeW-1:0]  gh;
    logic [RowW-1:0]   gw_mask;
    logic [RowW-1:0]   ch_mask;
    logic              cwise;
  } geom_t;

  // One column write into the destination buffer.
  typedef struct packed {
    logic               en;
    logic [RowIdxW-1:0] col;
    logic [RowW-1:0]    bits;
  } col_wr_t;

  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v,
                                                  input logic [SizeW-1:0] hi);
    logic [SizeW-1:0] r;
    r = v;
    if (v == '0) r = SizeW'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

  function automatic geom_t calc_geom(input logic [SizeW-1:0] cw_r,
                                      input logic [SizeW-1:0] ch_r,
                                      input logic [SizeW-1:0] iw_r,
                                      input logic [SizeW-1:0] ih_r,
                                      input logic             cwise);
    geom_t             g;
    logic [SizeW-1:0]  cw;
    logic [SizeW-1:0]  ch;
    logic [SizeW-1:0]  gw;
    logic [SizeW-1:0]  gh;
    logic signed [6:0] hw;
    logic signed [6:0] hh;
    cw = clamp_size(cw_r, SizeW'(MaxWidth));
    ch = clamp_size(ch_r, SizeW'(MaxHeight));
    gw = clamp_size(iw_r, cw);
    gh = clamp_size(ih_r, ch);
    hw = $signed({2'b00, gw[SizeW-1:1]});
    hh = $signed({2'b00, gh[SizeW-1:1]});
    g.cw      = cw;
    g.ch      = ch;
    g.gh      = gh;
    g.cwise   = cwise;
    g.gw_mask = ~({RowW{1'b1}} << gw);
    g.ch_mask = ~({RowW{1'b1}} << ch);
    if (cwise) begin
      // top row l1 = gh/2 + gw/2 - 1, word is bit-reversed before alignment
      g.shift    = hh + hw - 7'sd1 - 7'(RowW - 1);
      g.col_base = hw - hh;
    end else begin
      g.shift    = hh - hw;
      g.col_base = hw + hh - 7'sd1;
    end
    return g;
  endfunction

endpackage

[hw/rtl/gbr90_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gbr90_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/gbr90_scatter.sv]
// Shared rotate unit: turns one source row into one destination column.
// Depends on gbr90_pkg for the geometry and column-write types.
module gbr90_scatter import gbr90_pkg::*; (
  input  geom_t              geom_i,
  input  logic               vld_i,
  input  logic [RowIdxW-1:0] idx_i,
  input  logic [RowW-1:0]    src_i,
  output col_wr_t            wr_o
);

  logic signed [6:0] col;
  logic signed [6:0] idx_s;
  logic [6:0]        neg_shift;
  logic [RowW-1:0]   ink;
  logic [RowW-1:0]   word;
  logic [RowW-1:0]   aligned;

  assign idx_s = $signed({{(7-RowIdxW){1'b0}}, idx_i});
  assign col   = geom_i.cwise ? geom_i.col_base + idx_s : geom_i.col_base - idx_s;
  assign ink   = src_i & geom_i.gw_mask;
  assign neg_shift = 7'(-geom_i.shift);

  always_comb begin
    for (int k = 0; k < RowW; k++) begin
      word[k] = geom_i.cwise ? ink[RowW-1-k] : ink[k];
    end
    if (geom_i.shift[6]) begin
      aligned = word >> neg_shift[5:0];
    end else begin
      aligned = word << geom_i.shift[5:0];
    end
  end

  assign wr_o.en   = vld_i && !col[6] && (col[5:0] < geom_i.cw);
  assign wr_o.col  = col[RowIdxW-1:0];
  assign wr_o.bits = aligned & geom_i.ch_mask;

endmodule

[hw/rtl/gbr90_dest.sv]
// Destination cell buffer: column writes while scanning, row shift-out while emitting.
// Depends on gbr90_pkg for the column-write type.
module gbr90_dest import gbr90_pkg::*; (
  input  logic            clk_i,
  input  logic            clear_i,
  input  col_wr_t         wr_i,
  input  logic            shift_i,
  output logic [RowW-1:0] head_o
);

  logic [RowW-1:0] row_q [MaxHeight];

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < MaxHeight; r++) begin
      if (clear_i) begin
        row_q[r] <= '0;
      end else if (wr_i.en) begin
        row_q[r][wr_i.col] <= wr_i.bits[r];
      end else if (shift_i) begin
        row_q[r] <= (r == MaxHeight - 1) ? '0 : row_q[(r + 1) % MaxHeight];
      end
    end
  end

  assign head_o = row_q[0];

endmodule

[hw/rtl/glyph_bitmap_rotate_90_unit.sv]
// Glyph cell 90-degree rotator, top level.
// Depends on gbr90_pkg, gbr90_ram, gbr90_scatter and gbr90_dest.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o, row_bits_i) takes one source cell
//   row per beat, bit j being column j. One beat is taken per cycle while
//   loading. The beat that completes cell_height rows starts the rotation.
//   The block then drops in_ready_o, reads the ink rows back from the row
//   RAM one per cycle and folds each into one destination column through a
//   shared rotate unit.
//   Next the output channel (out_valid_o/out_ready_i) carries cell_height
//   result beats, one row each, at up to one per cycle from the registered
//   row buffer; last_row_o marks the final row. A stalled receiver simply
//   holds the current row; nothing is lost. After the last beat the block
//   takes rows again in the following cycle.
//   Configuration writes (cfg_valid_i/cfg_ready_o, cfg_addr_i, cfg_data_i)
//   are always taken; write only while the block is idle.
//   Reset clears the row count and loads the default 8x16 geometry.
module glyph_bitmap_rotate_90_unit import gbr90_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [RowW-1:0]     row_bits_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [RowW-1:0]     rotated_row_o,
  output logic                last_row_o
);

  // Configuration registers.
  logic [SizeW-1:0] cell_w_q, cell_h_q, ink_w_q, ink_h_q;
  logic             cwise_q;

  // Sequencer.
  state_e             state_q, state_d;
  logic [SizeW-1:0]   rows_q, rows_d;      // rows loaded for this cell
  logic [SizeW-1:0]   scan_q, scan_d;      // next RAM row to read
  logic [SizeW-1:0]   emit_q, emit_d;      // result rows delivered
  logic               rd_vld_q, rd_vld_d;  // RAM data valid this cycle
  logic [RowIdxW-1:0] rd_idx_q, rd_idx_d;
  geom_t              geom_q, geom_now;

  logic            in_beat, out_beat, last_load, rd_en, dest_clear;
  logic [SizeW-1:0] rows_inc;
  logic [RowW-1:0] ram_rdata;
  col_wr_t         col_wr;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_w_q <= CellWidthRst;
      cell_h_q <= CellHeightRst;
      ink_w_q  <= InkWidthRst;
      ink_h_q  <= InkHeightRst;
      cwise_q  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_CELL_WIDTH:  cell_w_q <= cfg_data_i[SizeW-1:0];
        CFG_CELL_HEIGHT: cell_h_q <= cfg_data_i[SizeW-1:0];
        CFG_INK_WIDTH:   ink_w_q  <= cfg_data_i[SizeW-1:0];
        CFG_INK_HEIGHT:  ink_h_q  <= cfg_data_i[SizeW-1:0];
        CFG_CLOCKWISE:   cwise_q  <= cfg_data_i[0];
        default:         ; // drop writes beyond the register list
      endcase
    end
  end

  assign geom_now  = calc_geom(cell_w_q, cell_h_q, ink_w_q, ink_h_q, cwise_q);
  assign in_beat   = in_valid_i && in_ready_o;
  assign out_beat  = out_valid_o && out_ready_i;
  assign rows_inc  = rows_q + SizeW'(1);
  assign last_load = in_beat && (rows_inc >= geom_now.ch);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      rows_q   <= '0;
      scan_q   <= '0;
      emit_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rows_q   <= rows_d;
      scan_q   <= scan_d;
      emit_q   <= emit_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  // Payload-only registers.
  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    if (last_load) begin
      geom_q <= geom_now;
    end
  end

  always_comb begin
    state_d     = state_q;
    rows_d      = rows_q;
    scan_d      = scan_q;
    emit_d      = emit_q;
    rd_en       = 1'b0;
    rd_vld_d    = 1'b0;
    rd_idx_d    = scan_q[RowIdxW-1:0];
    dest_clear  = 1'b0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (last_load) begin
          // last row of the cell: clear the buffer and start the scan
          rows_d     = '0;
          scan_d     = '0;
          dest_clear = 1'b1;
          state_d    = ST_SCAN;
        end else if (in_beat) begin
          rows_d = rows_inc;
        end
      end
      ST_SCAN: begin
        if (scan_q < geom_q.gh) begin
          rd_en    = 1'b1;
          rd_vld_d = 1'b1;
          scan_d   = scan_q + SizeW'(1);
        end
        if (rd_vld_q && (SizeW'(rd_idx_q) == geom_q.gh - SizeW'(1))) begin
          emit_d  = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_beat) begin
          emit_d = emit_q + SizeW'(1);
          if (last_row_o) begin
            state_d = ST_LOAD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  assign last_row_o = (emit_q == geom_q.ch - SizeW'(1));

  gbr90_ram #(
    .Width (RowW),
    .Depth (MaxHeight)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (in_beat),
    .waddr_i (rows_q[RowIdxW-1:0]),
    .wdata_i (row_bits_i),
    .re_i    (rd_en),
    .raddr_i (scan_q[RowIdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  gbr90_scatter u_scatter (
    .geom_i (geom_q),
    .vld_i  (rd_vld_q),
    .idx_i  (rd_idx_q),
    .src_i  (ram_rdata),
    .wr_o   (col_wr)
  );

  gbr90_dest u_dest (
    .clk_i   (clk_i),
    .clear_i (dest_clear),
    .wr_i    (col_wr),
    .shift_i (out_beat),
    .head_o  (rotated_row_o)
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output open together");

  a_last_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && last_row_o |=> in_ready_o)
    else $error("block did not return to loading after last row");

  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> emit_q < geom_q.ch)
    else $error("emit count beyond cell height");

  a_rd_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> state_q == ST_SCAN)
    else $error("row read data outside scan");

  a_col_in_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_wr.en |-> SizeW'(col_wr.col) < geom_q.cw)
    else $error("column write outside cell");
`endif

endmodule
